FILE: sv/mlqs_pkg.sv
// Package for the multilevel queue scheduler: sizes, codes and shared types.
// No dependencies; every other file but mlqs_ram refers to it by scoped names.
package mlqs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumQueues  = 3;
  localparam int unsigned IdW        = 8;
  localparam int unsigned DurW       = 8;
  localparam int unsigned SlackW     = 4;
  localparam int unsigned QuantW     = 8;
  localparam int unsigned ResQuantW  = 9;
  localparam int unsigned ClassW     = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam int unsigned PtrW     = $clog2(QueueDepth);
  localparam int unsigned CntW     = $clog2(QueueDepth + 1);
  localparam int unsigned RamDepth = NumQueues * QueueDepth;
  localparam int unsigned RamAddrW = $clog2(RamDepth);
  localparam int unsigned RamW     = IdW + DurW;

  localparam logic [ClassW-1:0] CLS_SYSTEM      = 2'd0;
  localparam logic [ClassW-1:0] CLS_INTERACTIVE = 2'd1;
  localparam logic [ClassW-1:0] CLS_BACKGROUND  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_SYSTEM_SLACK        = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERACTIVE_QUANTUM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BACKGROUND_QUANTUM  = 2'd2;

  localparam logic [SlackW-1:0] SystemSlackRst        = 4'd2;
  localparam logic [QuantW-1:0] InteractiveQuantumRst = 8'd2;
  localparam logic [QuantW-1:0] BackgroundQuantumRst  = 8'd1;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SELECT  = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_SELECTED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [SlackW-1:0] system_slack;
    logic [QuantW-1:0] interactive_quantum;
    logic [QuantW-1:0] background_quantum;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [ClassW-1:0] cls;
  } issue_t;

endpackage

FILE: sv/mlqs_if.sv
// Handshake channels of the scheduler: request words in, result words out.
// Depends on mlqs_pkg for field widths.
interface mlqs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [mlqs_pkg::IdW-1:0]     task_id;
  logic [mlqs_pkg::ClassW-1:0]  task_class;
  logic [mlqs_pkg::DurW-1:0]    duration;

  modport source (output valid, opcode, task_id, task_class, duration, input ready);
  modport sink   (input valid, opcode, task_id, task_class, duration, output ready);
endinterface

interface mlqs_out_if;
  logic                           valid;
  logic                           ready;
  logic [mlqs_pkg::StatusW-1:0]   status;
  logic [mlqs_pkg::IdW-1:0]       chosen_id;
  logic [mlqs_pkg::ClassW-1:0]    chosen_class;
  logic [mlqs_pkg::ResQuantW-1:0] quantum;
  logic                           preemptible;

  modport source (output valid, status, chosen_id, chosen_class, quantum, preemptible,
                  input ready);
  modport sink   (input valid, status, chosen_id, chosen_class, quantum, preemptible,
                  output ready);
endinterface

FILE: sv/mlqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mlqs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mlqs_ctrl.sv
// Queue bookkeeping: pointers, fill counts, config registers, RAM access issue.
// Depends on mlqs_pkg and mlqs_in_if.
module mlqs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlqs_in_if.sink                       in_i,
  input  logic                          cfg_we_i,
  input  logic [mlqs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlqs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          take_i,
  output mlqs_pkg::issue_t              issue_o,
  output mlqs_pkg::cfg_t                cfg_o,
  output logic                          ram_we_o,
  output logic                          ram_re_o,
  output logic [mlqs_pkg::RamAddrW-1:0] ram_addr_o,
  output logic [mlqs_pkg::RamW-1:0]     ram_wdata_o
);

  logic [mlqs_pkg::PtrW-1:0] rd_ptr_q [mlqs_pkg::NumQueues];
  logic [mlqs_pkg::PtrW-1:0] wr_ptr_q [mlqs_pkg::NumQueues];
  logic [mlqs_pkg::CntW-1:0] cnt_q    [mlqs_pkg::NumQueues];

  mlqs_pkg::issue_t  s1_q, s1_d;
  mlqs_pkg::cfg_t    cfg_q;
  mlqs_pkg::status_e status;

  logic                        acc, is_sel, empty, full, do_wr, do_rd;
  logic [mlqs_pkg::ClassW-1:0] cls_eff, qsel, tgt;
  logic [mlqs_pkg::CntW-1:0]   cnt_t;
  logic [mlqs_pkg::PtrW-1:0]   ptr_used, ptr_nxt;

  assign in_i.ready = !s1_q.valid || take_i;
  assign acc        = in_i.valid && in_i.ready;
  assign is_sel     = (mlqs_pkg::op_e'(in_i.opcode) == mlqs_pkg::OP_SELECT);
  assign cls_eff    = in_i.task_class[1] ? mlqs_pkg::CLS_BACKGROUND : in_i.task_class;

  always_comb begin
    empty = 1'b0;
    priority if (cnt_q[0] != '0) begin
      qsel = mlqs_pkg::CLS_SYSTEM;
    end else if (cnt_q[1] != '0) begin
      qsel = mlqs_pkg::CLS_INTERACTIVE;
    end else if (cnt_q[2] != '0) begin
      qsel = mlqs_pkg::CLS_BACKGROUND;
    end else begin
      qsel  = mlqs_pkg::CLS_BACKGROUND;
      empty = 1'b1;
    end
  end

  assign tgt      = is_sel ? qsel : cls_eff;
  assign cnt_t    = cnt_q[tgt];
  assign full     = (cnt_t == mlqs_pkg::CntW'(mlqs_pkg::QueueDepth));
  assign ptr_used = is_sel ? rd_ptr_q[tgt] : wr_ptr_q[tgt];
  assign ptr_nxt  = (ptr_used == mlqs_pkg::PtrW'(mlqs_pkg::QueueDepth - 1))
                    ? '0 : ptr_used + 1'b1;
  assign do_wr    = acc && !is_sel && !full;
  assign do_rd    = acc && is_sel && !empty;

  always_comb begin
    if (is_sel) begin
      status = empty ? mlqs_pkg::ST_EMPTY : mlqs_pkg::ST_SELECTED;
    end else begin
      status = full ? mlqs_pkg::ST_DROPPED : mlqs_pkg::ST_ENQUEUED;
    end
  end

  // queue base is class times depth
  assign ram_addr_o  = mlqs_pkg::RamAddrW'(tgt) * mlqs_pkg::RamAddrW'(mlqs_pkg::QueueDepth)
                       + mlqs_pkg::RamAddrW'(ptr_used);
  assign ram_wdata_o = {in_i.duration, in_i.task_id};
  assign ram_we_o    = do_wr;
  assign ram_re_o    = do_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mlqs_pkg::NumQueues); i++) begin
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      if (do_wr) begin
        wr_ptr_q[tgt] <= ptr_nxt;
        cnt_q[tgt]    <= cnt_t + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q[tgt] <= ptr_nxt;
        cnt_q[tgt]    <= cnt_t - 1'b1;
      end
    end
  end

  always_comb begin
    s1_d = s1_q;
    if (acc) begin
      s1_d.valid  = 1'b1;
      s1_d.status = status;
      s1_d.cls    = qsel;
    end else if (take_i) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.system_slack        <= mlqs_pkg::SystemSlackRst;
      cfg_q.interactive_quantum <= mlqs_pkg::InteractiveQuantumRst;
      cfg_q.background_quantum  <= mlqs_pkg::BackgroundQuantumRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlqs_pkg::CFG_SYSTEM_SLACK:
          cfg_q.system_slack <= cfg_data_i[mlqs_pkg::SlackW-1:0];
        mlqs_pkg::CFG_INTERACTIVE_QUANTUM:
          cfg_q.interactive_quantum <= cfg_data_i[mlqs_pkg::QuantW-1:0];
        mlqs_pkg::CFG_BACKGROUND_QUANTUM:
          cfg_q.background_quantum <= cfg_data_i[mlqs_pkg::QuantW-1:0];
        default: ;
      endcase
    end
  end

  assign issue_o = s1_q;
  assign cfg_o   = cfg_q;

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("RAM written and read by one word");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= mlqs_pkg::CntW'(mlqs_pkg::QueueDepth) &&
    cnt_q[1] <= mlqs_pkg::CntW'(mlqs_pkg::QueueDepth) &&
    cnt_q[2] <= mlqs_pkg::CntW'(mlqs_pkg::QueueDepth))
    else $error("fill count above queue depth");

  a_read_means_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |=> s1_q.valid && s1_q.status == mlqs_pkg::ST_SELECTED)
    else $error("RAM read without a selected word in flight");

  a_write_means_enqueued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> s1_q.valid && s1_q.status == mlqs_pkg::ST_ENQUEUED)
    else $error("RAM write without an enqueued word in flight");

endmodule

FILE: sv/mlqs_out.sv
// Result stage: combines RAM read data with config into the output register.
// Depends on mlqs_pkg and mlqs_out_if.
module mlqs_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mlqs_pkg::issue_t          issue_i,
  input  mlqs_pkg::cfg_t            cfg_i,
  input  logic [mlqs_pkg::RamW-1:0] rdata_i,
  output logic                      take_o,
  mlqs_out_if.source                out_o
);

  logic                           valid_q;
  logic [mlqs_pkg::StatusW-1:0]   status_q, status_d;
  logic [mlqs_pkg::IdW-1:0]       id_q, id_d;
  logic [mlqs_pkg::ClassW-1:0]    cls_q, cls_d;
  logic [mlqs_pkg::ResQuantW-1:0] quant_q, quant_d;
  logic                           pre_q, pre_d;

  assign take_o = issue_i.valid && (!valid_q || out_o.ready);

  always_comb begin
    status_d = issue_i.status;
    id_d     = '0;
    cls_d    = '0;
    quant_d  = '0;
    pre_d    = 1'b0;
    if (issue_i.status == mlqs_pkg::ST_SELECTED) begin
      id_d  = rdata_i[mlqs_pkg::IdW-1:0];
      cls_d = issue_i.cls;
      unique case (issue_i.cls)
        mlqs_pkg::CLS_SYSTEM: begin
          quant_d = mlqs_pkg::ResQuantW'(rdata_i[mlqs_pkg::RamW-1:mlqs_pkg::IdW])
                    + mlqs_pkg::ResQuantW'(cfg_i.system_slack);
          pre_d   = 1'b0;
        end
        mlqs_pkg::CLS_INTERACTIVE: begin
          quant_d = mlqs_pkg::ResQuantW'(cfg_i.interactive_quantum);
          pre_d   = 1'b1;
        end
        default: begin
          quant_d = mlqs_pkg::ResQuantW'(cfg_i.background_quantum);
          pre_d   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      status_q <= status_d;
      id_q     <= id_d;
      cls_q    <= cls_d;
      quant_q  <= quant_d;
      pre_q    <= pre_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.status       = status_q;
  assign out_o.chosen_id    = id_q;
  assign out_o.chosen_class = cls_q;
  assign out_o.quantum      = quant_q;
  assign out_o.preemptible  = pre_q;

  a_system_not_preemptible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && issue_i.status == mlqs_pkg::ST_SELECTED && issue_i.cls == mlqs_pkg::CLS_SYSTEM
    |=> out_o.valid && !out_o.preemptible)
    else $error("system task marked preemptible");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && issue_i.status != mlqs_pkg::ST_SELECTED
    |=> out_o.chosen_id == '0 && out_o.quantum == '0 && !out_o.preemptible)
    else $error("non-select word carries task fields");

  a_take_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> issue_i.valid)
    else $error("result stage loaded with nothing pending");

endmodule

FILE: sv/multilevel_queue_scheduler.sv
// Top level of the strict-priority multilevel queue scheduler.
// Depends on mlqs_pkg, mlqs_if, mlqs_ram, mlqs_ctrl and mlqs_out.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    opcode, task_id, task_class, duration
//   out_o    out  valid/ready    status, chosen_id, chosen_class, quantum, preemptible
//   cfg      in   cfg_we_i only  cfg_idx_i, cfg_data_i
//
// Each accepted word is held in the issue register, with its queue RAM access, and
// then in the result register. Pointers and fill counts update on
// acceptance, so a new word may be taken every cycle. Reset clears pointers and counts,
// loads config defaults; queue RAM contents need no clearing. A stalled result holds
// the output register and the issue stage, and the input stops once both are full.
module multilevel_queue_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlqs_in_if.sink                       in_i,
  mlqs_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [mlqs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlqs_pkg::CfgDataW-1:0] cfg_data_i
);

  mlqs_pkg::issue_t              issue;
  mlqs_pkg::cfg_t                cfg;
  logic                          take;
  logic                          ram_we, ram_re;
  logic [mlqs_pkg::RamAddrW-1:0] ram_addr;
  logic [mlqs_pkg::RamW-1:0]     ram_wdata, ram_rdata;

  mlqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .issue_o     (issue),
    .cfg_o       (cfg),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  mlqs_ram #(
    .Width (mlqs_pkg::RamW),
    .Depth (mlqs_pkg::RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  mlqs_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .cfg_i   (cfg),
    .rdata_i (ram_rdata),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule

FILE: test/tb_multilevel_queue_scheduler.sv
// Testbench for multilevel_queue_scheduler: directed table, then random words in several
// register settings; results checked against table rows or a mirror of the ready queues.
// Depends on mlqs_pkg, mlqs_in_if, mlqs_out_if and the scheduler RTL.
module tb_multilevel_queue_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles = 40;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned PhaseWords = 100;
  localparam int unsigned NumPhases  = 5;

  typedef struct packed {
    mlqs_pkg::op_e               op;
    logic [mlqs_pkg::IdW-1:0]    id;
    logic [mlqs_pkg::ClassW-1:0] cls;
    logic [mlqs_pkg::DurW-1:0]   dur;
  } word_t;

  typedef struct packed {
    mlqs_pkg::status_e              status;
    logic [mlqs_pkg::IdW-1:0]       id;
    logic [mlqs_pkg::ClassW-1:0]    cls;
    logic [mlqs_pkg::ResQuantW-1:0] quantum;
    logic                           preemptible;
  } outcome_t;

  typedef struct packed {
    logic     typed;
    outcome_t res;
  } hint_t;

  typedef struct packed {
    word_t w;
    hint_t h;
  } row_t;

  typedef struct packed {
    logic [mlqs_pkg::IdW-1:0]  id;
    logic [mlqs_pkg::DurW-1:0] dur;
  } sys_task_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mlqs_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [mlqs_pkg::CfgDataW-1:0] cfg_data_i;

  mlqs_in_if  in_ch ();
  mlqs_out_if out_ch ();

  multilevel_queue_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // mirror of the ready queues and registers
  sys_task_t                   sys_q[$];
  logic [mlqs_pkg::IdW-1:0]    ia_q[$];
  logic [mlqs_pkg::IdW-1:0]    bg_q[$];
  logic [mlqs_pkg::SlackW-1:0] slack      = mlqs_pkg::SystemSlackRst;
  logic [mlqs_pkg::QuantW-1:0] ia_quantum = mlqs_pkg::InteractiveQuantumRst;
  logic [mlqs_pkg::QuantW-1:0] bg_quantum = mlqs_pkg::BackgroundQuantumRst;

  outcome_t outcome_q[$];
  hint_t    hint_q[$];
  int       errors      = 0;
  int       idle_cycles = 0;
  bit       jitter      = 1'b1;
  bit       hold_req    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic outcome_t pick_task(word_t w);
    outcome_t                    o;
    sys_task_t                   t;
    logic [mlqs_pkg::ClassW-1:0] c;
    o = '0;
    c = (w.cls > mlqs_pkg::CLS_BACKGROUND) ? mlqs_pkg::CLS_BACKGROUND : w.cls;
    if (w.op == mlqs_pkg::OP_ENQUEUE) begin
      o.status = mlqs_pkg::ST_ENQUEUED;
      if (c == mlqs_pkg::CLS_SYSTEM) begin
        t.id  = w.id;
        t.dur = w.dur;
        if (sys_q.size() < mlqs_pkg::QueueDepth) sys_q = {sys_q, t};
        else o.status = mlqs_pkg::ST_DROPPED;
      end else if (c == mlqs_pkg::CLS_INTERACTIVE) begin
        if (ia_q.size() < mlqs_pkg::QueueDepth) ia_q = {ia_q, w.id};
        else o.status = mlqs_pkg::ST_DROPPED;
      end else begin
        if (bg_q.size() < mlqs_pkg::QueueDepth) bg_q = {bg_q, w.id};
        else o.status = mlqs_pkg::ST_DROPPED;
      end
    end else if (sys_q.size() != 0) begin
      t = sys_q[0];
      sys_q.delete(0);
      o.status      = mlqs_pkg::ST_SELECTED;
      o.id          = t.id;
      o.cls         = mlqs_pkg::CLS_SYSTEM;
      o.quantum     = mlqs_pkg::ResQuantW'(t.dur) + mlqs_pkg::ResQuantW'(slack);
      o.preemptible = 1'b0;
    end else if (ia_q.size() != 0) begin
      o.status      = mlqs_pkg::ST_SELECTED;
      o.id          = ia_q[0];
      ia_q.delete(0);
      o.cls         = mlqs_pkg::CLS_INTERACTIVE;
      o.quantum     = mlqs_pkg::ResQuantW'(ia_quantum);
      o.preemptible = 1'b1;
    end else if (bg_q.size() != 0) begin
      o.status      = mlqs_pkg::ST_SELECTED;
      o.id          = bg_q[0];
      bg_q.delete(0);
      o.cls         = mlqs_pkg::CLS_BACKGROUND;
      o.quantum     = mlqs_pkg::ResQuantW'(bg_quantum);
      o.preemptible = 1'b1;
    end else begin
      o.status = mlqs_pkg::ST_EMPTY;
    end
    return o;
  endfunction

  function automatic row_t entry(mlqs_pkg::op_e op, logic [mlqs_pkg::IdW-1:0] id,
                                 logic [mlqs_pkg::ClassW-1:0] cls,
                                 logic [mlqs_pkg::DurW-1:0] dur, logic typed,
                                 mlqs_pkg::status_e st, logic [mlqs_pkg::IdW-1:0] cid,
                                 logic [mlqs_pkg::ClassW-1:0] ccls,
                                 logic [mlqs_pkg::ResQuantW-1:0] q, logic pre);
    row_t r;
    r.w.op              = op;
    r.w.id              = id;
    r.w.cls             = cls;
    r.w.dur             = dur;
    r.h.typed           = typed;
    r.h.res.status      = st;
    r.h.res.id          = cid;
    r.h.res.cls         = ccls;
    r.h.res.quantum     = q;
    r.h.res.preemptible = pre;
    return r;
  endfunction

  function automatic word_t random_word(int unsigned enq_pct);
    word_t w;
    w.op  = ($urandom_range(0, 99) < enq_pct) ? mlqs_pkg::OP_ENQUEUE : mlqs_pkg::OP_SELECT;
    w.id  = mlqs_pkg::IdW'($urandom);
    w.cls = mlqs_pkg::ClassW'($urandom);
    w.dur = mlqs_pkg::DurW'($urandom);
    return w;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic offer(word_t w, hint_t h);
    if (jitter && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    hint_q = {hint_q, h};
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= w.op;
    in_ch.task_id    <= w.id;
    in_ch.task_class <= w.cls;
    in_ch.duration   <= w.dur;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_setting(logic [mlqs_pkg::SlackW-1:0] s, logic [mlqs_pkg::QuantW-1:0] iq,
                              logic [mlqs_pkg::QuantW-1:0] bq);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mlqs_pkg::CFG_SYSTEM_SLACK;
    cfg_data_i <= {mlqs_pkg::SlackW'($urandom), s};
    @(posedge clk_i);
    cfg_idx_i  <= mlqs_pkg::CFG_INTERACTIVE_QUANTUM;
    cfg_data_i <= iq;
    @(posedge clk_i);
    cfg_idx_i  <= mlqs_pkg::CFG_BACKGROUND_QUANTUM;
    cfg_data_i <= bq;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    slack      = s;
    ia_quantum = iq;
    bg_quantum = bq;
  endtask

  always @(posedge clk_i) begin : monitor
    word_t    w;
    outcome_t want;
    hint_t    h;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        w.op  = mlqs_pkg::op_e'(in_ch.opcode);
        w.id  = in_ch.task_id;
        w.cls = in_ch.task_class;
        w.dur = in_ch.duration;
        want  = pick_task(w);
        if (hint_q.size() != 0) begin
          h = hint_q[0];
          hint_q.delete(0);
          if (h.typed) want = h.res;
        end
        outcome_q = {outcome_q, want};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no expectation waiting");
          errors++;
        end else begin
          want = outcome_q[0];
          outcome_q.delete(0);
          check_field("status", want.status, out_ch.status);
          check_field("chosen_id", want.id, out_ch.chosen_id);
          check_field("chosen_class", want.cls, out_ch.chosen_class);
          check_field("quantum", want.quantum, out_ch.quantum);
          check_field("preemptible", want.preemptible, out_ch.preemptible);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (jitter && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    row_t        rows[$];
    hint_t       none;
    int unsigned enq_pct;
    none = '0;

    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= mlqs_pkg::OP_ENQUEUE;
    in_ch.task_id    <= '0;
    in_ch.task_class <= mlqs_pkg::CLS_SYSTEM;
    in_ch.duration   <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= mlqs_pkg::CFG_SYSTEM_SLACK;
    cfg_data_i       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset quanta: slack 2, interactive 2, background 1
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'h00, mlqs_pkg::CLS_SYSTEM, 8'h00, 1'b1,
                        mlqs_pkg::ST_EMPTY, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, 8'hFF, mlqs_pkg::CLS_SYSTEM, 8'hFF, 1'b1,
                        mlqs_pkg::ST_ENQUEUED, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, 8'h00, mlqs_pkg::CLS_INTERACTIVE, 8'hFF, 1'b1,
                        mlqs_pkg::ST_ENQUEUED, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, 8'hA5, mlqs_pkg::CLS_BACKGROUND, 8'h00, 1'b1,
                        mlqs_pkg::ST_ENQUEUED, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, 8'h5A, 2'd3, 8'h00, 1'b1,
                        mlqs_pkg::ST_ENQUEUED, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'h00, mlqs_pkg::CLS_SYSTEM, 8'h00, 1'b1,
                        mlqs_pkg::ST_SELECTED, 8'hFF, mlqs_pkg::CLS_SYSTEM, 9'd257, 1'b0)};
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'hFF, 2'd3, 8'hFF, 1'b1,
                        mlqs_pkg::ST_SELECTED, 8'h00, mlqs_pkg::CLS_INTERACTIVE, 9'd2, 1'b1)};
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'h00, mlqs_pkg::CLS_SYSTEM, 8'h00, 1'b1,
                        mlqs_pkg::ST_SELECTED, 8'hA5, mlqs_pkg::CLS_BACKGROUND, 9'd1, 1'b1)};
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'h00, mlqs_pkg::CLS_SYSTEM, 8'h00, 1'b1,
                        mlqs_pkg::ST_SELECTED, 8'h5A, mlqs_pkg::CLS_BACKGROUND, 9'd1, 1'b1)};
    rows = {rows, entry(mlqs_pkg::OP_SELECT, 8'h00, mlqs_pkg::CLS_SYSTEM, 8'h00, 1'b1,
                        mlqs_pkg::ST_EMPTY, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    // fill the system queue, then one word too many
    for (int k = 0; k < mlqs_pkg::QueueDepth; k++) begin
      rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, mlqs_pkg::IdW'(k * 17), mlqs_pkg::CLS_SYSTEM,
                          mlqs_pkg::DurW'(k * 16 + 15), 1'b0, mlqs_pkg::ST_ENQUEUED, 8'h00,
                          mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    end
    rows = {rows, entry(mlqs_pkg::OP_ENQUEUE, 8'h3C, mlqs_pkg::CLS_SYSTEM, 8'h77, 1'b1,
                        mlqs_pkg::ST_DROPPED, 8'h00, mlqs_pkg::CLS_SYSTEM, 9'd0, 1'b0)};
    foreach (rows[i]) offer(rows[i].w, rows[i].h);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: load_setting(4'd15, 8'd255, 8'd255);
        1: load_setting(4'd0, 8'd0, 8'd0);
        3: load_setting(4'd0, 8'd1, 8'd1);
        default: load_setting(mlqs_pkg::SlackW'($urandom),
                              mlqs_pkg::QuantW'($urandom_range(1, 255)),
                              mlqs_pkg::QuantW'($urandom_range(1, 255)));
      endcase
      if (p == 2) hold_req = 1'b1;
      if (p == NumPhases - 1) jitter = 1'b0;
      enq_pct = 50;
      for (int i = 0; i < PhaseWords; i++) begin
        if (i % 25 == 0) begin
          case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
          endcase
        end
        offer(random_word(enq_pct), none);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mlqs_pkg.sv
sv/mlqs_if.sv
sv/mlqs_ram.sv
sv/mlqs_ctrl.sv
sv/mlqs_out.sv
sv/multilevel_queue_scheduler.sv
test/tb_multilevel_queue_scheduler.sv
